// ===== rtl/core/fpmu_pkg.sv =====
// Shared types and constants of the fixed-point matrix unit.
package fpmu_pkg;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [2:0] MODE_MUL    = 3'd0;
  localparam logic [2:0] MODE_AT_MUL = 3'd1;
  localparam logic [2:0] MODE_BT_MUL = 3'd2;
  localparam logic [2:0] MODE_ADD    = 3'd3;
  localparam logic [2:0] MODE_SUB    = 3'd4;
  localparam logic [2:0] MODE_SCALE  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd5;

  typedef enum logic [1:0] {
    KIND_MAC   = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_SUB   = 2'd2,
    KIND_SCALE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [DIM_W-1:0]  a_rows;
    logic [DIM_W-1:0]  a_cols;
    logic [DIM_W-1:0]  b_rows;
    logic [DIM_W-1:0]  b_cols;
    logic [2:0]        op_mode;
    logic [DATA_W-1:0] scale_factor;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    kind_t kind;
  } mac_tag_t;

endpackage

// ===== rtl/core/fpmu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/core/fpmu_mac.sv =====
// Shared multiply/add unit: operand stage, product stage, accumulate stage.
module fpmu_mac
  import fpmu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mac_tag_t          tag_in,
  input  logic [DATA_W-1:0] a_data,
  input  logic [DATA_W-1:0] b_data,
  input  logic [DATA_W-1:0] scale,
  output logic              acc_valid_r,
  output logic [DATA_W-1:0] acc_r
);

  mac_tag_t                 tag1_r;
  mac_tag_t                 tag2_r;
  logic [DATA_W-1:0]        op_b;
  logic signed [2*DATA_W-1:0] prod_r;
  logic [DATA_W-1:0]        sum_r;
  logic [DATA_W-1:0]        term;
  logic [DATA_W-1:0]        acc_nxt;
  logic                     acc_valid_nxt;

  // Tag follows the RAM read latency by one stage.
  assign op_b = (tag1_r.kind == KIND_SCALE) ? scale : b_data;

  // Q16.16 product: arithmetic shift by 16, truncated to 32 bits.
  assign term = (tag2_r.kind == KIND_ADD || tag2_r.kind == KIND_SUB) ?
                sum_r : prod_r[DATA_W+15:16];

  always_comb begin
    acc_nxt       = acc_r;
    acc_valid_nxt = acc_valid_r;
    if (tag2_r.valid) begin
      acc_nxt = (tag2_r.first ? '0 : acc_r) + term;
    end
    if (tag_in.valid && tag_in.first) begin
      acc_valid_nxt = 1'b0;
    end else if (tag2_r.valid && tag2_r.last) begin
      acc_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      acc_valid_r <= 1'b0;
    end else begin
      tag1_r      <= tag_in;
      tag2_r      <= tag1_r;
      acc_valid_r <= acc_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(a_data) * $signed(op_b);
    sum_r  <= (tag1_r.kind == KIND_SUB) ? (a_data - op_b) : (a_data + op_b);
    acc_r  <= acc_nxt;
  end

endmodule

// ===== rtl/core/fpmu_ctrl.sv =====
// Sequencer: dimension check, operand address walk and output word register.
module fpmu_ctrl
  import fpmu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_stall,
  output logic [ADDR_W-1:0] a_raddr,
  output logic [ADDR_W-1:0] b_raddr,
  output mac_tag_t          tag,
  input  logic              acc_valid,
  input  logic [DATA_W-1:0] acc_value,
  output logic              out_valid_r,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_value_r,
  output logic [ADDR_W-1:0] out_index_r,
  output logic              out_last_r,
  output logic              out_err_r
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_ERR   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [DIM_W-1:0]  r_r, r_nxt, c_r, c_nxt, e_r, e_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;

  logic [DIM_W-1:0]   rr, rc, k_len;
  logic [2*DIM_W-1:0] total;
  logic               ok, shape_a, shape_b;
  logic               accept, slot_free, elem_last, e_last;
  logic               out_load, out_err_load;
  kind_t              kind;
  logic [2*DIM_W:0]   a_full, b_full;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && ({1'b0, d} <= (DIM_W+1)'(MAX_DIM));
  endfunction

  function automatic logic shape_ok(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
    logic [2*DIM_W-1:0] n;
    n = {{DIM_W{1'b0}}, r} * {{DIM_W{1'b0}}, c};
    return dim_ok(r) && dim_ok(c) && (n <= (2*DIM_W)'(STORE_DEPTH));
  endfunction

  assign shape_a = shape_ok(cfg.a_rows, cfg.a_cols);
  assign shape_b = shape_ok(cfg.b_rows, cfg.b_cols);

  // Result shape, inner length, operation kind and dimension check for the current mode.
  always_comb begin
    rr    = cfg.a_rows;
    rc    = cfg.a_cols;
    k_len = {{(DIM_W-1){1'b0}}, 1'b1};
    kind  = KIND_MAC;
    ok    = 1'b0;
    case (cfg.op_mode)
      MODE_MUL: begin
        rc    = cfg.b_cols;
        k_len = cfg.a_cols;
        ok    = shape_a && shape_b && (cfg.a_cols == cfg.b_rows);
      end
      MODE_AT_MUL: begin
        rr    = cfg.a_cols;
        rc    = cfg.b_cols;
        k_len = cfg.a_rows;
        ok    = shape_a && shape_b && (cfg.a_rows == cfg.b_rows);
      end
      MODE_BT_MUL: begin
        rc    = cfg.b_rows;
        k_len = cfg.a_cols;
        ok    = shape_a && shape_b && (cfg.a_cols == cfg.b_cols);
      end
      MODE_ADD, MODE_SUB: begin
        kind = (cfg.op_mode == MODE_ADD) ? KIND_ADD : KIND_SUB;
        ok   = shape_a && shape_b && (cfg.a_rows == cfg.b_rows) &&
               (cfg.a_cols == cfg.b_cols);
      end
      MODE_SCALE: begin
        kind = KIND_SCALE;
        ok   = shape_a;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign total = {{DIM_W{1'b0}}, rr} * {{DIM_W{1'b0}}, rc};

  // Operand addresses in row-major order.
  always_comb begin
    a_full = {{(DIM_W+1){1'b0}}, pos_r[DIM_W-1:0]};
    b_full = a_full;
    case (cfg.op_mode)
      MODE_MUL: begin
        a_full = {{(DIM_W+1){1'b0}}, r_r} * {{(DIM_W+1){1'b0}}, cfg.a_cols}
                 + {{(DIM_W+1){1'b0}}, e_r};
        b_full = {{(DIM_W+1){1'b0}}, e_r} * {{(DIM_W+1){1'b0}}, cfg.b_cols}
                 + {{(DIM_W+1){1'b0}}, c_r};
      end
      MODE_AT_MUL: begin
        a_full = {{(DIM_W+1){1'b0}}, e_r} * {{(DIM_W+1){1'b0}}, cfg.a_cols}
                 + {{(DIM_W+1){1'b0}}, r_r};
        b_full = {{(DIM_W+1){1'b0}}, e_r} * {{(DIM_W+1){1'b0}}, cfg.b_cols}
                 + {{(DIM_W+1){1'b0}}, c_r};
      end
      MODE_BT_MUL: begin
        a_full = {{(DIM_W+1){1'b0}}, r_r} * {{(DIM_W+1){1'b0}}, cfg.a_cols}
                 + {{(DIM_W+1){1'b0}}, e_r};
        b_full = {{(DIM_W+1){1'b0}}, c_r} * {{(DIM_W+1){1'b0}}, cfg.b_cols}
                 + {{(DIM_W+1){1'b0}}, e_r};
      end
      default: begin
        a_full = {{(2*DIM_W+1-ADDR_W){1'b0}}, pos_r};
        b_full = a_full;
      end
    endcase
  end

  assign a_raddr = a_full[ADDR_W-1:0];
  assign b_raddr = b_full[ADDR_W-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign e_last    = (e_r == k_len - 1'b1);
  assign elem_last = (({{DIM_W{1'b0}}, pos_r} + 1'b1) == {{(ADDR_W-DIM_W){1'b0}}, total});

  always_comb begin
    state_nxt    = state_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    e_nxt        = e_r;
    pos_nxt      = pos_r;
    tag          = '0;
    tag.kind     = kind;
    out_load     = 1'b0;
    out_err_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_func == FUNC_COMPUTE) begin
          r_nxt     = '0;
          c_nxt     = '0;
          e_nxt     = '0;
          pos_nxt   = '0;
          state_nxt = ok ? S_ISSUE : S_ERR;
        end
      end
      S_ISSUE: begin
        tag.valid = 1'b1;
        tag.first = (e_r == '0);
        tag.last  = e_last;
        if (e_last) begin
          e_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          e_nxt = e_r + 1'b1;
        end
      end
      S_WAIT: begin
        if (acc_valid && slot_free) begin
          out_load = 1'b1;
          if (elem_last) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = S_ISSUE;
            if (c_r == rc - 1'b1) begin
              c_nxt = '0;
              r_nxt = r_r + 1'b1;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_err_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || out_err_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    c_r   <= c_nxt;
    e_r   <= e_nxt;
    pos_r <= pos_nxt;
    if (out_load) begin
      out_value_r <= acc_value;
      out_index_r <= pos_r;
      out_last_r  <= elem_last;
      out_err_r   <= 1'b0;
    end else if (out_err_load) begin
      out_value_r <= '0;
      out_index_r <= '0;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load || out_err_load) |-> !(out_valid_r && out_stall))
    else $error("output word loaded over a stalled word");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_last_r && out_index_r == '0))
    else $error("error word without last marker or with nonzero index");

  a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && !acc_valid) |=> (state_r == S_WAIT))
    else $error("sequencer left wait before the accumulator finished");

  a_inner_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (e_r < k_len))
    else $error("inner index ran past the inner dimension");

endmodule

// ===== rtl/core/fixed_point_matrix_unit.sv =====
// Top level of the Q16.16 fixed-point matrix unit.
// Load: a load word gives no result; a compute with bad dimensions passes through the error
// state and gives its single error word through the output register once the output is free.
// Elements run one at a time on the one shared multiply-accumulate unit, which accumulates a
// product-mode element over the inner dimension; no word is taken meanwhile.
// Reset: rst_n (synchronous, active low) resets config, state and flags; stores are undefined.
module fixed_point_matrix_unit
  import fpmu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic [ADDR_W-1:0]    in_elem_index,
  input  logic signed [DATA_W-1:0] in_elem_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DATA_W-1:0] out_value,
  output logic [ADDR_W-1:0]    out_index,
  output logic                 out_last,
  output logic                 out_dim_error
);

  // Configuration registers. Writes to an index beyond the list are ignored.
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_A_ROWS: cfg_nxt.a_rows       = cfg_data[DIM_W-1:0];
        CFG_A_COLS: cfg_nxt.a_cols       = cfg_data[DIM_W-1:0];
        CFG_B_ROWS: cfg_nxt.b_rows       = cfg_data[DIM_W-1:0];
        CFG_B_COLS: cfg_nxt.b_cols       = cfg_data[DIM_W-1:0];
        CFG_MODE:   cfg_nxt.op_mode      = cfg_data[2:0];
        CFG_SCALE:  cfg_nxt.scale_factor = cfg_data;
        default:    cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_rows       <= DIM_W'(1);
      cfg_r.a_cols       <= DIM_W'(1);
      cfg_r.b_rows       <= DIM_W'(1);
      cfg_r.b_cols       <= DIM_W'(1);
      cfg_r.op_mode      <= MODE_MUL;
      cfg_r.scale_factor <= DATA_W'(65536);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Load words write straight into the stores; the sequencer only takes
  // words while it is idle, so a write never meets a compute read.
  logic in_accept;
  logic a_we, b_we;

  assign in_accept = in_valid && !in_stall;
  assign a_we      = in_accept && (in_func == FUNC_LOAD_A);
  assign b_we      = in_accept && (in_func == FUNC_LOAD_B);

  logic [ADDR_W-1:0] a_raddr, b_raddr;
  logic [DATA_W-1:0] a_rdata, b_rdata;
  mac_tag_t          tag;
  logic              acc_valid;
  logic [DATA_W-1:0] acc_value;
  logic [DATA_W-1:0] out_value_w;

  fpmu_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_a_store (
    .clk    (clk),
    .we     (a_we),
    .waddr  (in_elem_index),
    .wdata  (in_elem_value),
    .raddr  (a_raddr),
    .rdata_r(a_rdata)
  );

  fpmu_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_b_store (
    .clk    (clk),
    .we     (b_we),
    .waddr  (in_elem_index),
    .wdata  (in_elem_value),
    .raddr  (b_raddr),
    .rdata_r(b_rdata)
  );

  // The one arithmetic unit: it multiplies and accumulates for the product
  // modes, and adds, subtracts or scales once per element otherwise.
  fpmu_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag_in     (tag),
    .a_data     (a_rdata),
    .b_data     (b_rdata),
    .scale      (cfg_r.scale_factor),
    .acc_valid_r(acc_valid),
    .acc_r      (acc_value)
  );

  // Sequencer with the output word register; the register lets a finished
  // word wait for the consumer while the block idles for the next word.
  fpmu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_func    (in_func),
    .in_stall   (in_stall),
    .a_raddr    (a_raddr),
    .b_raddr    (b_raddr),
    .tag        (tag),
    .acc_valid  (acc_valid),
    .acc_value  (acc_value),
    .out_valid_r(out_valid),
    .out_stall  (out_stall),
    .out_value_r(out_value_w),
    .out_index_r(out_index),
    .out_last_r (out_last),
    .out_err_r  (out_dim_error)
  );

  assign out_value = $signed(out_value_w);

endmodule
